// ===== rtl/mkpt_pkg.sv =====
// Package with the operation codes and cell action codes of the MRU profile table.
`timescale 1ns / 1ps

package mkpt_pkg;

    // Operation codes carried on the op field of an input transfer.
    localparam logic [2:0] OP_UPSERT = 3'd0;
    localparam logic [2:0] OP_TOUCH  = 3'd1;
    localparam logic [2:0] OP_ERASE  = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // What a table cell does with its contents at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_PREV  = 2'd1,
        CELL_NEXT  = 2'd2,
        CELL_CLEAR = 2'd3
    } cell_act_t;

endpackage

// ===== rtl/mkpt_cell.sv =====
// One table cell: a key and payload register with a local key comparator.
`timescale 1ns / 1ps

module mkpt_cell
    import mkpt_pkg::*;
#(
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_act_t               act,
    input  logic [KEY_BITS-1:0]     cmp_key,
    input  logic [KEY_BITS-1:0]     prev_key,
    input  logic [PAYLOAD_BITS-1:0] prev_payload,
    input  logic [KEY_BITS-1:0]     next_key,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    output logic [KEY_BITS-1:0]     key_out,
    output logic [PAYLOAD_BITS-1:0] payload_out,
    output logic                    match
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        unique case (act)
            CELL_HOLD:
            begin
                key_next     = key_reg;
                payload_next = payload_reg;
            end
            CELL_PREV:
            begin
                key_next     = prev_key;
                payload_next = prev_payload;
            end
            CELL_NEXT:
            begin
                key_next     = next_key;
                payload_next = next_payload;
            end
            CELL_CLEAR:
            begin
                key_next     = '0;
                payload_next = '0;
            end
            default:
            begin
                key_next     = key_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            payload_reg <= '0;
        end
        else
        begin
            key_reg     <= key_next;
            payload_reg <= payload_next;
        end
    end

    assign key_out     = key_reg;
    assign payload_out = payload_reg;
    assign match       = (key_reg == cmp_key);

endmodule

// ===== rtl/mru_keyed_profile_table_core.sv =====
// Top level of the bounded most-recently-used key and payload table.
`timescale 1ns / 1ps

// The table keeps up to ENTRIES key and payload pairs in a row of cells,
// ordered from the most recent (position 0) to the oldest. Each operation
// has a lookup step and an update step: in the cycle of the input transfer
// every cell compares its key with the incoming key and the match flags are
// registered; then the first match is located, the cells shift toward or
// away from the front by one position in a single step, and the result is
// written into the output register. A new input transfer is taken as soon as
// the update cycle has run, even while the previous result still waits in the
// output register; the update cycle itself waits only if that register is
// still full. A key of zero marks an empty slot and never matches. Upsert
// moves an existing key to the front with its new payload or inserts the
// pair at the front, dropping the oldest entry when the table is full. Touch
// moves a found key to the front, erase removes it and closes the gap, clear
// empties the table and find reports position and payload. Every operation
// gives exactly one result; hit_index is the position of the key before any
// move, and entry_count is the number of entries after the operation, both
// truncated to the width of their ports.

module mru_keyed_profile_table_core
    import mkpt_pkg::*;
#(
    parameter int ENTRIES      = 8,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              op,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    ok,
    output logic [2:0]              hit_index,
    output logic [PAYLOAD_BITS-1:0] hit_payload,
    output logic [3:0]              entry_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Command captured at the input transfer.
    logic                    busy_reg;
    logic [2:0]              op_reg;
    logic [KEY_BITS-1:0]     cmd_key_reg;
    logic [PAYLOAD_BITS-1:0] cmd_payload_reg;
    logic [ENTRIES-1:0]      match_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // Output register.
    logic                    out_valid_reg;
    logic                    ok_reg;
    logic                    ok_next;
    logic [2:0]              hit_index_reg;
    logic [2:0]              hit_index_next;
    logic [PAYLOAD_BITS-1:0] hit_payload_reg;
    logic [PAYLOAD_BITS-1:0] hit_payload_next;
    logic [3:0]              entry_count_reg;

    // Cell row.
    logic [KEY_BITS-1:0]     cell_key [ENTRIES];
    logic [PAYLOAD_BITS-1:0] cell_payload [ENTRIES];
    logic [ENTRIES-1:0]      cell_match;
    cell_act_t               cell_act [ENTRIES];

    // Lookup results in the update cycle.
    logic                    in_xfer;
    logic                    exec;
    logic                    found;
    logic [ENTRIES-1:0]      found_above;
    logic [ENTRIES-1:0]      first_hit;
    logic [IDX_W-1:0]        hit_pos;
    logic [PAYLOAD_BITS-1:0] sel_payload;
    logic [PAYLOAD_BITS-1:0] front_payload;
    logic [IDX_W+2:0]        hit_pos_ext;
    logic [CNT_W+3:0]        count_ext;

    assign in_ready = !busy_reg;
    assign in_xfer  = in_valid && in_ready;
    assign exec     = busy_reg && (!out_valid_reg || out_ready);

    // The row of cells. Cell 0 takes the new front entry through its
    // upstream port; the last cell takes zeros when the row closes a gap.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]     up_key;
        logic [PAYLOAD_BITS-1:0] up_payload;
        logic [KEY_BITS-1:0]     dn_key;
        logic [PAYLOAD_BITS-1:0] dn_payload;

        if (i == 0)
        begin : g_head
            assign up_key     = cmd_key_reg;
            assign up_payload = front_payload;
        end
        else
        begin : g_body
            assign up_key     = cell_key[i-1];
            assign up_payload = cell_payload[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_tail
            assign dn_key     = '0;
            assign dn_payload = '0;
        end
        else
        begin : g_inner
            assign dn_key     = cell_key[i+1];
            assign dn_payload = cell_payload[i+1];
        end

        mkpt_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .act          (cell_act[i]),
            .cmp_key      (key),
            .prev_key     (up_key),
            .prev_payload (up_payload),
            .next_key     (dn_key),
            .next_payload (dn_payload),
            .key_out      (cell_key[i]),
            .payload_out  (cell_payload[i]),
            .match        (cell_match[i])
        );
    end

    // Locate the first match. Keys are unique in the table, so at most one
    // flag is set; the priority still keeps the first position on its own.
    always_comb
    begin
        logic [ENTRIES-1:0] below_mask;
        found       = |match_reg;
        hit_pos     = '0;
        sel_payload = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            below_mask     = (ENTRIES'(1) << i) - ENTRIES'(1);
            found_above[i] = |(match_reg & below_mask);
            first_hit[i]   = match_reg[i] && !found_above[i];
            if (first_hit[i])
            begin
                hit_pos     = hit_pos | IDX_W'(i);
                sel_payload = sel_payload | cell_payload[i];
            end
        end
    end

    // Upsert brings the new payload to the front; touch brings the stored one.
    assign front_payload = (op_reg == OP_UPSERT) ? cmd_payload_reg : sel_payload;
    assign hit_pos_ext   = {3'b000, hit_pos};

    // Cell actions and result of the update cycle.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_act[i] = CELL_HOLD;
        end
        count_next       = count_reg;
        ok_next          = 1'b0;
        hit_index_next   = found ? hit_pos_ext[2:0] : 3'b000;
        hit_payload_next = '0;

        if (exec)
        begin
            case (op_reg)
                OP_UPSERT:
                begin
                    if (cmd_key_reg != '0)
                    begin
                        // Entries above the hit (all of them on a miss) move
                        // back by one; on a miss the oldest falls off the end.
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            cell_act[i] = found_above[i] ? CELL_HOLD : CELL_PREV;
                        end
                        if (!found && (count_reg < CNT_W'(ENTRIES)))
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        ok_next = 1'b1;
                    end
                end
                OP_TOUCH:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            cell_act[i] = found_above[i] ? CELL_HOLD : CELL_PREV;
                        end
                        ok_next = 1'b1;
                    end
                end
                OP_ERASE:
                begin
                    if (found)
                    begin
                        // The hit and everything behind it move forward by
                        // one; the last cell fills with zeros.
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            cell_act[i] = (found_above[i] || match_reg[i]) ?
                                          CELL_NEXT : CELL_HOLD;
                        end
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        cell_act[i] = CELL_CLEAR;
                    end
                    count_next     = '0;
                    ok_next        = 1'b1;
                    hit_index_next = 3'b000;
                end
                OP_FIND:
                begin
                    if (found)
                    begin
                        hit_payload_next = sel_payload;
                        ok_next          = 1'b1;
                    end
                end
                default:
                begin
                    hit_index_next = 3'b000;
                end
            endcase
        end
    end

    assign count_ext = {4'b0000, count_next};

    // Command capture and the busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            match_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                busy_reg  <= 1'b1;
                match_reg <= (key != '0) ? cell_match : '0;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg          <= op;
            cmd_key_reg     <= key;
            cmd_payload_reg <= payload;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            ok_reg          <= ok_next;
            hit_index_reg   <= hit_index_next;
            hit_payload_reg <= hit_payload_next;
            entry_count_reg <= count_ext[3:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign hit_index   = hit_index_reg;
    assign hit_payload = hit_payload_reg;
    assign entry_count = entry_count_reg;

    // The fill count never runs past the size of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    // Keys stay unique, so a lookup hits at most one cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("key stored in more than one cell");

    // An empty table holds a zero key at the front.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cell_key[0] == '0))
        else $error("empty table holds a key");

    // A waiting result reports the current fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (entry_count_reg == count_ext[3:0]) || exec)
        else $error("reported entry count out of step with the table");

endmodule
